// ===== rtl/core/b2d_pkg.sv =====
// b2d_pkg: shared types and constants for the binary to decimal ASCII converter.
// Used by b2d_front, b2d_queue, b2d_back and binary_to_decimal_ascii.
// No dependencies.
package b2d_pkg;

   // One BCD digit
   localparam int DIGIT_BITS = 4;
   typedef logic [DIGIT_BITS-1:0] bcd_digit_type;

   // Shift-add-3 correction: digits of 5 and up get 3 added before the shift
   localparam bcd_digit_type BCD_ADJ_MIN = 4'd5;
   localparam bcd_digit_type BCD_ADJ_ADD = 4'd3;
   localparam bcd_digit_type BCD_ZERO    = 4'd0;

   // ASCII '0' is 6'b110000, so a digit character is this zone over the BCD digit
   localparam logic [1:0] ASCII_ZONE = 2'b11;

   // Status of the queue between conversion and emission
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/core/b2d_front.sv =====
// b2d_front: accepts a value and converts it to packed BCD by shift-add-3,
// one input bit per cycle, then pushes the BCD word to the queue.
// Depends on b2d_pkg.
module b2d_front import b2d_pkg::*; #(
   parameter int VALUE_BITS = 64,
   parameter int NUM_DIGITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [VALUE_BITS-1:0]            value,
   input  logic                             q_full,
   output logic                             q_push,
   output logic [NUM_DIGITS*DIGIT_BITS-1:0] q_push_data
);

   localparam int BCD_W = NUM_DIGITS * DIGIT_BITS;
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      bcd_adj;
   logic                  accept;
   logic                  conv_done;

   // Add-3 correction on every digit (digits are independent)
   always_comb begin
      bcd_digit_type d;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         d = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
         bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = (d >= BCD_ADJ_MIN) ? d + BCD_ADJ_ADD : d;
      end
   end

   assign accept    = start && !busy_ff;
   assign conv_done = busy_ff && (cnt_ff == '0);
   assign q_push    = conv_done && !q_full;

   // Conversion sequencer
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      if (accept) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(VALUE_BITS);
         shift_in = value;
         bcd_in   = '0;
      end else if (busy_ff && cnt_ff != '0) begin
         cnt_in   = cnt_ff - 1'b1;
         shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in   = {bcd_adj[BCD_W-2:0], shift_ff[VALUE_BITS-1]};
      end else if (q_push) begin
         busy_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
   end

   assign busy        = busy_ff;
   assign q_push_data = bcd_ff;

endmodule

// ===== rtl/core/b2d_queue.sv =====
// b2d_queue: small register FIFO holding converted BCD words.
// Depends on b2d_pkg.
module b2d_queue import b2d_pkg::*; #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output q_status_type     status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/core/b2d_back.sv =====
// b2d_back: takes BCD words from the queue, skips leading zero digits and
// emits one ASCII digit per cycle, most significant first.
// Depends on b2d_pkg.
module b2d_back import b2d_pkg::*; #(
   parameter int NUM_DIGITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  logic [NUM_DIGITS*DIGIT_BITS-1:0] q_pop_data,
   output logic                             q_pop,
   output logic                             rsp_strobe,
   output logic [5:0]                       rsp_digit_char,
   output logic                             rsp_last_digit
);

   localparam int BCD_W = NUM_DIGITS * DIGIT_BITS;
   localparam int IW    = $clog2(NUM_DIGITS);

   logic             act_ff, act_in;
   logic             started_ff, started_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [BCD_W-1:0] dig_ff, dig_in;
   logic             strobe_ff;
   logic [5:0]       char_ff;
   logic             last_ff;
   bcd_digit_type    cur;
   logic             at_end;
   logic             emit;

   // Top digit decides: skip a leading zero or emit
   assign cur    = dig_ff[BCD_W-1 -: DIGIT_BITS];
   assign at_end = (idx_ff == IW'(NUM_DIGITS - 1));
   assign emit   = act_ff && (started_ff || cur != BCD_ZERO || at_end);
   assign q_pop  = !q_empty && (!act_ff || (emit && at_end));

   always_comb begin
      act_in     = act_ff;
      started_in = started_ff;
      idx_in     = idx_ff;
      dig_in     = dig_ff;
      if (q_pop) begin
         act_in     = 1'b1;
         started_in = 1'b0;
         idx_in     = '0;
         dig_in     = q_pop_data;
      end else if (act_ff) begin
         act_in     = !at_end;
         started_in = started_ff || emit;
         idx_in     = idx_ff + 1'b1;
         dig_in     = {dig_ff[BCD_W-DIGIT_BITS-1:0], BCD_ZERO};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff     <= 1'b0;
         started_ff <= 1'b0;
         idx_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         act_ff     <= act_in;
         started_ff <= started_in;
         idx_ff     <= idx_in;
         strobe_ff  <= emit;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      char_ff <= {ASCII_ZONE, cur};
      last_ff <= at_end;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// binary_to_decimal_ascii: top level of the binary to decimal ASCII converter.
// Depends on b2d_pkg, b2d_front, b2d_queue and b2d_back.
//
// Converts the low VALUE_BITS bits of req_value to decimal ASCII text. A
// transaction is taken when start is high and busy is low. The front converts
// by shift-add-3, one input bit per cycle, and busy stays high until the
// converted word is pushed to the queue, so the front takes one value at a
// time. The converted word passes through a
// two-entry queue to the back end, which skips leading zeros and then emits one
// digit per cycle on rsp_strobe, most significant first, rsp_last_digit on
// the final digit; zero gives a single '0'. The back end keeps pace with
// the front. The
// receiver cannot stall: each digit is valid for exactly one cycle.
module binary_to_decimal_ascii import b2d_pkg::*; #(
   parameter int VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_digit_char,
   output logic        rsp_last_digit
);

   // Decimal digits needed for VALUE_BITS bits: floor(n*log10(2)) + 1
   localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_BITS;
   localparam int Q_DEPTH    = 2;

   logic             q_push;
   logic             q_pop;
   logic [BCD_W-1:0] q_push_data;
   logic [BCD_W-1:0] q_pop_data;
   q_status_type     q_stat;

   b2d_front #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .value       (req_value[VALUE_BITS-1:0]),
      .q_full      (q_stat.full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   b2d_queue #(
      .WIDTH (BCD_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_stat)
   );

   b2d_back #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_stat.empty),
      .q_pop_data     (q_pop_data),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

`ifndef SYNTH
   // An accepted transaction keeps the front busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("front not busy after accepting a transaction");

   // Queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full && !q_pop))
      else $error("push into full queue");

   // Queue never underflows
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_stat.empty))
      else $error("pop from empty queue");

   // Every emitted character is a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_digit_char[5:4] == ASCII_ZONE && rsp_digit_char[3:0] <= 4'd9))
      else $error("emitted character is not a decimal digit");
`endif

endmodule

// ===== tb/binary_to_decimal_ascii_checker.sv =====
// binary_to_decimal_ascii_checker: predicts and checks the digit stream of the converter.
// Watches the command and digit channels of binary_to_decimal_ascii; no other dependencies.
// Hands its failure count and the number of digits still awaited to the testbench top.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_checker #(
   parameter int VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [63:0] req_value,
   input  logic        rsp_strobe,
   input  logic [5:0]  rsp_digit_char,
   input  logic        rsp_last_digit,
   output int          fail_count,
   output int          pending_count
);

   localparam int          MAX_DIGITS = 20;
   localparam logic [63:0] DEC_BASE   = 64'd10;
   localparam logic [7:0]  ASCII_ZERO = 8'd48;

   typedef struct packed {
      logic [5:0] digit_char;
      logic       last_digit;
   } digit_rsp_type;

   // Digits still owed by the block, oldest first
   digit_rsp_type digit_q [$];
   digit_rsp_type exp_digit;

   // Decimal expansion of one transaction, most significant digit first
   function automatic void queue_decimal_digits(input logic [63:0] value);
      logic [63:0]   v;
      logic [3:0]    rev_digits [MAX_DIGITS];
      int            n;
      digit_rsp_type d;
      v = (VALUE_BITS >= 64) ? value : (value & ((64'd1 << VALUE_BITS) - 64'd1));
      n = 0;
      do begin
         rev_digits[n] = 4'(v % DEC_BASE);
         v = v / DEC_BASE;
         n++;
      end while (v != 0 && n < MAX_DIGITS);
      for (int k = n - 1; k >= 0; k--) begin
         d.digit_char = 6'(ASCII_ZERO + 8'(rev_digits[k]));
         d.last_digit = (k == 0);
         digit_q.push_back(d);
      end
   endfunction

   // Sample both channels at the rising edge; inputs change only after it
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (digit_q.size() == 0) begin
               $error("unexpected digit: digit_char %0d, last_digit %0b",
                      rsp_digit_char, rsp_last_digit);
               fail_count++;
            end else begin
               exp_digit = digit_q.pop_front();
               if (rsp_digit_char !== exp_digit.digit_char) begin
                  $error("digit_char: expected %0d, actual %0d",
                         exp_digit.digit_char, rsp_digit_char);
                  fail_count++;
               end
               if (rsp_last_digit !== exp_digit.last_digit) begin
                  $error("last_digit: expected %0b, actual %0b",
                         exp_digit.last_digit, rsp_last_digit);
                  fail_count++;
               end
            end
         end
         // Transaction taken: start high while not busy
         if (start && !busy) begin
            queue_decimal_digits(req_value);
         end
      end
      pending_count = digit_q.size();
   end

endmodule

// ===== tb/binary_to_decimal_ascii_tb.sv =====
// binary_to_decimal_ascii_tb: stimulus and verdict for the binary to decimal ASCII converter.
// Depends on binary_to_decimal_ascii (and b2d_pkg) and binary_to_decimal_ascii_checker.
// Directed edge values first, then random values of every digit count, with random gaps.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;

   localparam int VALUE_BITS    = 64;
   localparam int RANDOM_ITEMS  = 260;
   // Front conversion plus up to 20 digits out of the back end, with margin
   localparam int SETTLE_CYCLES = VALUE_BITS + 2 + 40;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic [63:0] req_value = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [5:0]  rsp_digit_char;
   logic        rsp_last_digit;
   int          fail_count;
   int          pending_count;

   logic [63:0] directed_values [$] = '{
      64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd1000,
      64'd4294967296, 64'd999999999999999999, 64'd1000000000000000000,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'd9999999999999999999, 64'd10000000000000000000,
      64'd12345678901234567890, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF
   };

   binary_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last_digit(rsp_last_digit)
   );

   binary_to_decimal_ascii_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last_digit(rsp_last_digit),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Random value spread over all digit counts, with decade boundaries weighted up
   function automatic logic [63:0] random_value();
      logic [63:0] v;
      logic [63:0] decade;
      int          kind;
      int          n;
      kind = $urandom_range(0, 9);
      v    = {$urandom, $urandom};
      if (kind <= 3) begin
         v = v >> $urandom_range(0, 63);
      end else if (kind <= 5) begin
         // full width as is
      end else if (kind <= 7) begin
         decade = 64'd1;
         n      = $urandom_range(0, 19);
         repeat (n) decade = decade * 64'd10;
         v = decade - 64'd1 + 64'($urandom_range(0, 2));
      end else if (kind == 8) begin
         v = 64'($urandom_range(0, 1000));
      end else begin
         v[63] = 1'b1;
      end
      return v;
   endfunction

   // Idle cycles after a transaction: mostly none or short, sometimes long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11) return 0;
      if (r < 18) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   // One transaction: hold start until the block takes it, then maybe idle
   task automatic send_value(input logic [63:0] v);
      int gap;
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_values[i]) begin
         send_value(directed_values[i]);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_value(random_value());
      end
      start <= 1'b0;

      // Drain outstanding digits, then watch for stray ones
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
